/* hdl/priority_schedule_timing_macros.svh */
// Assertion macros shared by the priority scheduler RTL
`ifndef PRIORITY_SCHEDULE_TIMING_MACROS_SVH
`define PRIORITY_SCHEDULE_TIMING_MACROS_SVH

// Same-cycle implication, quiet during reset
`define PST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset
`define PST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/psched_pkg.sv */
// Types, sizes and helper functions of the priority scheduler
`timescale 1ns / 1ps
`default_nettype none

package psched_pkg;

    localparam int MAX_PROCS = 16;
    // Width of the record count, holds MAX_PROCS
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    // Schedule clock never exceeds (MAX_PROCS + 1) * 65535
    localparam int CLK_W     = 16 + $clog2(MAX_PROCS + 2);
    localparam int SUM_W     = CLK_W + $clog2(MAX_PROCS + 1);
    localparam int DVD_W     = SUM_W + 8;
    localparam int DCNT_W    = $clog2(DVD_W + 1);
    localparam int EXT_W     = (DVD_W > 29) ? DVD_W : 29;

    localparam logic [19:0] WAIT_MAX = 20'hFFFFF;
    localparam logic [20:0] TURN_MAX = 21'h1FFFFF;
    localparam logic [27:0] AVGW_MAX = 28'hFFFFFFF;
    localparam logic [28:0] AVGT_MAX = 29'h1FFFFFFF;

    typedef struct packed {
        logic [3:0]  proc_id;
        logic [15:0] arrival_time;
        logic [15:0] run_time;
        logic [7:0]  prio_value;
        logic        last_in;
    } t_in;

    typedef struct packed {
        logic [3:0]  out_id;
        logic [15:0] out_arrival;
        logic [15:0] out_run;
        logic [7:0]  out_prio;
        logic [19:0] wait_time;
        logic [20:0] turnaround_time;
        logic [27:0] avg_wait_q8;
        logic [28:0] avg_turn_q8;
        logic        last_out;
    } t_out;

    typedef struct packed {
        logic [3:0]  id;
        logic [15:0] arr;
        logic [15:0] run;
        logic [7:0]  pri;
    } t_rec;

    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_slot;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctl;

    function automatic logic [19:0] sat_wait(input logic [CLK_W-1:0] v);
        logic [EXT_W-1:0] x;
        x = EXT_W'(v);
        return (x > EXT_W'(WAIT_MAX)) ? WAIT_MAX : x[19:0];
    endfunction

    function automatic logic [20:0] sat_turn(input logic [CLK_W-1:0] v);
        logic [EXT_W-1:0] x;
        x = EXT_W'(v);
        return (x > EXT_W'(TURN_MAX)) ? TURN_MAX : x[20:0];
    endfunction

    function automatic logic [27:0] sat_avgw(input logic [DVD_W-1:0] v);
        logic [EXT_W-1:0] x;
        x = EXT_W'(v);
        return (x > EXT_W'(AVGW_MAX)) ? AVGW_MAX : x[27:0];
    endfunction

    function automatic logic [28:0] sat_avgt(input logic [DVD_W-1:0] v);
        logic [EXT_W-1:0] x;
        x = EXT_W'(v);
        return (x > EXT_W'(AVGT_MAX)) ? AVGT_MAX : x[28:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/psched_cell.sv */
// One slot of the sorted insertion chain
`timescale 1ns / 1ps
`default_nettype none

module psched_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire psched_pkg::t_cell_ctl i_ctl,
    input  wire psched_pkg::t_rec      i_new,
    input  wire logic                  i_prev_keep,
    input  wire psched_pkg::t_slot     i_left,
    input  wire psched_pkg::t_slot     i_right,
    output      psched_pkg::t_slot     o_slot,
    output      logic                  o_keep
);
    import psched_pkg::*;

    logic r_valid;
    t_rec r_rec;
    logic keep;

    // Hold the entry when it ranks at or before the new item (ties keep entry order)
    assign keep = r_valid && (r_rec.pri <= i_new.pri);

    // Valid bit: take right neighbour on drain, new or left neighbour on insert
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_right.valid;
        end else if (i_ctl.ins && !keep) begin
            r_valid <= i_prev_keep ? 1'b1 : i_left.valid;
        end
    end

    // Record payload follows the same choice
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_rec <= i_right.rec;
        end else if (i_ctl.ins && !keep) begin
            r_rec <= i_prev_keep ? i_new : i_left.rec;
        end
    end

    assign o_slot = '{valid: r_valid, rec: r_rec};
    assign o_keep = keep;

endmodule

`default_nettype wire

/* hdl/psched_div.sv */
// Restoring divider, one quotient bit per cycle, for the schedule averages
`timescale 1ns / 1ps
`default_nettype none

module psched_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [psched_pkg::DVD_W-1:0]  i_dvd,
    input  wire logic [psched_pkg::CNT_W-1:0]  i_dvs,
    output      logic                          o_done,
    output      logic [psched_pkg::DVD_W-1:0]  o_quo
);
    import psched_pkg::*;

    logic              r_run;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]  r_dvs;
    logic [CNT_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [CNT_W:0]    trial;
    logic              fits;

    // Bring down the next dividend bit and test against the divisor
    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    // Control: step count and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= DCNT_W'(DVD_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_dvs;
            r_rem <= '0;
            r_quo <= i_dvd;
        end else if (r_run) begin
            r_rem <= fits ? CNT_W'(trial - {1'b0, r_dvs}) : trial[CNT_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

/* hdl/priority_schedule_timing.sv */
// Top level of the non-preemptive priority scheduler
//
// Records are taken one per cycle while o_busy is low; each is placed into a
// sorted chain of MAX_PROCS cells in the cycle it is accepted, ordered by
// ascending priority with ties in entry order. The item with last_in set, or
// the one that fills the chain, closes the set and raises o_busy. The chain
// then drains one cell per cycle through the timing unit, so results 1 to n-1
// come on consecutive cycles after acceptance of the closing item. The last
// result waits for the shift-subtract divider that forms both averages and
// is registered when the divider reports done; o_busy falls as it is shown.
// Each result stands for exactly one cycle under o_strobe: the receiver cannot
// stall and must take every one.
`timescale 1ns / 1ps
`default_nettype none

`include "priority_schedule_timing_macros.svh"

module priority_schedule_timing (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire psched_pkg::t_in i_in,
    output      logic            o_busy,
    output      logic            o_strobe,
    output      psched_pkg::t_out o_out
);
    import psched_pkg::*;

    typedef enum logic [1:0] {
        S_LOAD,
        S_DRAIN,
        S_DIV
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] r_n;
    logic [CLK_W-1:0] r_clock;
    logic [SUM_W-1:0] r_sum_w;
    logic [SUM_W-1:0] r_sum_t;
    logic             r_strobe;
    t_out             r_out;
    t_out             r_final;

    logic             accept;
    logic             close_set;
    t_cell_ctl        ctl;
    t_rec             new_rec;
    t_slot            slots [MAX_PROCS];
    logic             keeps [MAX_PROCS];
    t_rec             head;
    logic [CLK_W-1:0] arr_ext;
    logic [CLK_W-1:0] start_t;
    logic [CLK_W-1:0] fin_t;
    logic [CLK_W-1:0] wait_t;
    logic [CLK_W-1:0] turn_t;
    logic [SUM_W-1:0] n_sum_w;
    logic [SUM_W-1:0] n_sum_t;
    t_out             cur_out;
    t_out             closing_out;
    t_out             avg_out;
    logic             div_start;
    logic             divw_done;
    logic             divt_done;
    logic [DVD_W-1:0] quo_w;
    logic [DVD_W-1:0] quo_t;

    assign o_busy    = (r_state != S_LOAD);
    assign accept    = i_start && !o_busy;
    assign close_set = i_in.last_in || (r_count == CNT_W'(MAX_PROCS - 1));

    assign new_rec = '{id: i_in.proc_id, arr: i_in.arrival_time,
                       run: i_in.run_time, pri: i_in.prio_value};

    // Insert on accept, shift towards the head while draining
    assign ctl = '{ins: accept, shift: (r_state == S_DRAIN)};

    // Build the chain of cells
    for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
        logic  prev_keep;
        t_slot left_slot;
        t_slot right_slot;

        if (g == 0) begin : g_first
            assign prev_keep = 1'b1;
            assign left_slot = '0;
        end else begin : g_mid
            assign prev_keep = keeps[g-1];
            assign left_slot = slots[g-1];
        end

        if (g == MAX_PROCS - 1) begin : g_last
            assign right_slot = '0;
        end else begin : g_inner
            assign right_slot = slots[g+1];
        end

        psched_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_new       (new_rec),
            .i_prev_keep (prev_keep),
            .i_left      (left_slot),
            .i_right     (right_slot),
            .o_slot      (slots[g]),
            .o_keep      (keeps[g])
        );
    end

    // Time the record at the head of the chain
    assign head    = slots[0].rec;
    assign arr_ext = CLK_W'(head.arr);
    assign start_t = (r_clock > arr_ext) ? r_clock : arr_ext;
    assign fin_t   = start_t + CLK_W'(head.run);
    assign wait_t  = start_t - arr_ext;
    assign turn_t  = fin_t - arr_ext;
    assign n_sum_w = r_sum_w + SUM_W'(wait_t);
    assign n_sum_t = r_sum_t + SUM_W'(turn_t);

    assign cur_out = '{out_id: head.id, out_arrival: head.arr, out_run: head.run,
                       out_prio: head.pri, wait_time: sat_wait(wait_t),
                       turnaround_time: sat_turn(turn_t), avg_wait_q8: '0,
                       avg_turn_q8: '0, last_out: 1'b0};

    // Mark the final record and attach the averages to it
    always_comb begin
        closing_out          = cur_out;
        closing_out.last_out = 1'b1;
        avg_out              = r_final;
        avg_out.avg_wait_q8  = sat_avgw(quo_w);
        avg_out.avg_turn_q8  = sat_avgt(quo_t);
    end

    // Start both averages once the final record is timed
    assign div_start = (r_state == S_DRAIN) && (r_left == CNT_W'(1));

    psched_div u_div_wait (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   ({n_sum_w, 8'h00}),
        .i_dvs   (r_n),
        .o_done  (divw_done),
        .o_quo   (quo_w)
    );

    psched_div u_div_turn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   ({n_sum_t, 8'h00}),
        .i_dvs   (r_n),
        .o_done  (divt_done),
        .o_quo   (quo_t)
    );

    // Sequencer: load, drain, divide; results registered here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_left   <= '0;
            r_n      <= '0;
            r_clock  <= '0;
            r_sum_w  <= '0;
            r_sum_t  <= '0;
            r_strobe <= 1'b0;
            r_out    <= '0;
            r_final  <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (close_set) begin
                            r_left  <= r_count + 1'b1;
                            r_n     <= r_count + 1'b1;
                            r_count <= '0;
                            r_clock <= '0;
                            r_sum_w <= '0;
                            r_sum_t <= '0;
                            r_state <= S_DRAIN;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_DRAIN: begin
                    r_clock <= fin_t;
                    r_sum_w <= n_sum_w;
                    r_sum_t <= n_sum_t;
                    r_left  <= r_left - 1'b1;
                    if (r_left == CNT_W'(1)) begin
                        r_final <= closing_out;
                        r_state <= S_DIV;
                    end else begin
                        r_out    <= cur_out;
                        r_strobe <= 1'b1;
                    end
                end
                S_DIV: begin
                    if (divw_done) begin
                        r_out    <= avg_out;
                        r_strobe <= 1'b1;
                        r_state  <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    // Checks on the sequencer
    `PST_ASSERT_NOW(a_last_frees, i_clk, i_rst_n, o_strobe && o_out.last_out, !o_busy, "busy at end")
    `PST_ASSERT_NEXT(a_close_busy, i_clk, i_rst_n, accept && i_in.last_in, o_busy, "close not busy")
    `PST_ASSERT_NOW(a_head_valid, i_clk, i_rst_n, r_state == S_DRAIN, slots[0].valid, "empty head")
    `PST_ASSERT_NOW(a_div_pair, i_clk, i_rst_n, divw_done || divt_done, divw_done && divt_done, "div skew")

endmodule

`default_nettype wire
